// File: hw/rtl/krt_pkg.sv
// krt_pkg: shared types and constants of the keyed record table.
// Used by krt_cell and keyed_record_table_top; depends on nothing.
`default_nettype none

package krt_pkg;

    localparam int TableDepth    = 16;
    localparam int KeyWidth      = 32;
    localparam int PayloadWidth  = 32;
    localparam int ProfileLimit  = 4;
    localparam int ProfileW      = 4;
    localparam int CfgW          = 5;
    localparam int CapacityReset = 16;

    typedef enum logic [2:0] {
        OP_ADD      = 3'd0,
        OP_REMOVE   = 3'd1,
        OP_FIND     = 3'd2,
        OP_SET_PROF = 3'd3,
        OP_GET      = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    // per-cell write controls for the update cycle
    typedef struct packed {
        logic shift;
        logic wr_entry;
        logic wr_profile;
    } t_cell_ctl;

endpackage

`default_nettype wire

// File: hw/rtl/krt_cell.sv
// krt_cell: one entry of the record table with its own key comparator.
// Depends on krt_pkg; chained into a row by keyed_record_table_top.
`default_nettype none

module krt_cell #(
    parameter int KEY_WIDTH     = krt_pkg::KeyWidth,
    parameter int PAYLOAD_WIDTH = krt_pkg::PayloadWidth
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cmp_en,
    input  wire logic [KEY_WIDTH-1:0]          i_cmp_key,
    input  wire logic                          i_live,
    input  wire logic                          i_seen,
    output logic                               o_seen,
    output logic                               o_first,
    input  wire krt_pkg::t_cell_ctl            i_ctl,
    input  wire logic [KEY_WIDTH-1:0]          i_wr_key,
    input  wire logic [krt_pkg::ProfileW-1:0]  i_wr_profile,
    input  wire logic [PAYLOAD_WIDTH-1:0]      i_wr_payload,
    input  wire logic [KEY_WIDTH-1:0]          i_nxt_key,
    input  wire logic [krt_pkg::ProfileW-1:0]  i_nxt_profile,
    input  wire logic [PAYLOAD_WIDTH-1:0]      i_nxt_payload,
    output logic [KEY_WIDTH-1:0]               o_key,
    output logic [krt_pkg::ProfileW-1:0]       o_profile,
    output logic [PAYLOAD_WIDTH-1:0]           o_payload
);

    logic                          r_match;
    logic [KEY_WIDTH-1:0]          r_key;
    logic [krt_pkg::ProfileW-1:0]  r_profile;
    logic [PAYLOAD_WIDTH-1:0]      r_payload;
    logic                          w_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_cmp_en) begin
            r_match <= (r_key == i_cmp_key);
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_ctl.shift) begin
            r_key     <= i_nxt_key;
            r_profile <= i_nxt_profile;
            r_payload <= i_nxt_payload;
        end else if (i_ctl.wr_entry) begin
            r_key     <= i_wr_key;
            r_profile <= i_wr_profile;
            r_payload <= i_wr_payload;
        end else if (i_ctl.wr_profile) begin
            r_profile <= i_wr_profile;
        end else begin
            // hold
        end
    end

    // lowest live match wins: seen ripples up the row
    assign w_hit     = r_match & i_live;
    assign o_first   = w_hit & ~i_seen;
    assign o_seen    = w_hit | i_seen;
    assign o_key     = r_key;
    assign o_profile = r_profile;
    assign o_payload = r_payload;

endmodule

`default_nettype wire

// File: hw/rtl/keyed_record_table_top.sv
// keyed_record_table_top: packed, insertion-ordered record table built as a row of cells.
// Depends on krt_pkg and krt_cell.
`default_nettype none

// In the transfer cycle every cell compares its stored key with the incoming key
// in parallel and registers the match; in the update state that follows, the
// lowest live match (for a get, the live entry at the given position) is picked
// along the row, the entries are written or shifted down one place, and the result
// is loaded into the output register. A new item is taken as soon as that update is
// done, even while the previous result waits for o_out_valid's counterpart
// i_out_ready; the update itself waits only when the output register is still full.
// Stored entries have no reset; only entries below the count are ever read.
// Configuration writes are always accepted.

module keyed_record_table_top #(
    parameter int TABLE_DEPTH   = krt_pkg::TableDepth,
    parameter int KEY_WIDTH     = krt_pkg::KeyWidth,
    parameter int PAYLOAD_WIDTH = krt_pkg::PayloadWidth,
    parameter int PROFILE_LIMIT = krt_pkg::ProfileLimit,
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [krt_pkg::CfgW-1:0]      i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [2:0]                    i_operation,
    input  wire logic [KEY_WIDTH-1:0]          i_device_key,
    input  wire logic [krt_pkg::ProfileW-1:0]  i_new_profile,
    input  wire logic [PAYLOAD_WIDTH-1:0]      i_new_payload,
    input  wire logic [IW-1:0]                 i_position,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_success,
    output logic [IW-1:0]                      o_hit_index,
    output logic [KEY_WIDTH-1:0]               o_hit_key,
    output logic [krt_pkg::ProfileW-1:0]       o_hit_profile,
    output logic [PAYLOAD_WIDTH-1:0]           o_hit_payload,
    output logic [CW-1:0]                      o_entry_count
);

    localparam int PW      = krt_pkg::ProfileW;
    localparam int CAPW    = (krt_pkg::CfgW > CW) ? krt_pkg::CfgW : CW;
    localparam int CAP_RST = (krt_pkg::CapacityReset > TABLE_DEPTH) ?
                             TABLE_DEPTH : krt_pkg::CapacityReset;
    localparam logic [PW:0]     PROF_LIM = (PW + 1)'(PROFILE_LIMIT);
    localparam logic [CAPW-1:0] DEPTH_C  = CAPW'(TABLE_DEPTH);

    krt_pkg::t_state  r_state;
    krt_pkg::t_op     r_op;
    logic [KEY_WIDTH-1:0]     r_key;
    logic [PW-1:0]            r_profile;
    logic [PAYLOAD_WIDTH-1:0] r_payload;
    logic [IW-1:0]            r_pos;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            r_cap;

    logic                     r_out_valid;
    logic                     r_success;
    logic [IW-1:0]            r_hit_index;
    logic [KEY_WIDTH-1:0]     r_hit_key;
    logic [PW-1:0]            r_hit_profile;
    logic [PAYLOAD_WIDTH-1:0] r_hit_payload;

    logic                     n_success;
    logic [IW-1:0]            n_hit_index;
    logic [KEY_WIDTH-1:0]     n_hit_key;
    logic [PW-1:0]            n_hit_profile;
    logic [PAYLOAD_WIDTH-1:0] n_hit_payload;
    logic [CW-1:0]            n_count;
    logic [TABLE_DEPTH-1:0]   n_wr_entry;
    logic [TABLE_DEPTH-1:0]   n_wr_profile;
    logic [TABLE_DEPTH-1:0]   n_shift;

    logic                     w_in_fire;
    logic                     w_go;
    logic [CAPW-1:0]          w_cfg_ext;
    logic [TABLE_DEPTH-1:0]   w_live;
    logic [TABLE_DEPTH-1:0]   w_first;
    logic [TABLE_DEPTH-1:0]   w_pick;
    logic [TABLE_DEPTH-1:0]   w_append;
    logic [TABLE_DEPTH:0]     w_seen;
    logic                     w_any;
    logic [IW-1:0]            w_first_idx;
    logic [KEY_WIDTH-1:0]     w_sel_key;
    logic [PW-1:0]            w_sel_profile;
    logic [PAYLOAD_WIDTH-1:0] w_sel_payload;
    logic                     w_pos_ok;
    logic                     w_prof_ok;

    logic [KEY_WIDTH-1:0]     w_cell_key     [TABLE_DEPTH];
    logic [PW-1:0]            w_cell_profile [TABLE_DEPTH];
    logic [PAYLOAD_WIDTH-1:0] w_cell_payload [TABLE_DEPTH];
    krt_pkg::t_cell_ctl       w_ctl          [TABLE_DEPTH];

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == krt_pkg::S_IDLE);
    assign w_in_fire   = i_in_valid & o_in_ready;
    assign w_go        = (r_state == krt_pkg::S_EXEC) & (~r_out_valid | i_out_ready);
    assign w_cfg_ext   = CAPW'(i_cfg_data);

    assign w_seen[0] = 1'b0;
    assign w_any     = w_seen[TABLE_DEPTH];

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_row
            localparam int NXT = (g + 1 < TABLE_DEPTH) ? g + 1 : g;

            assign w_live[g]   = (CW'(g) < r_count);
            assign w_append[g] = (CW'(g) == r_count);
            assign w_ctl[g]    = '{shift:      n_shift[g],
                                   wr_entry:   n_wr_entry[g],
                                   wr_profile: n_wr_profile[g]};

            krt_cell #(
                .KEY_WIDTH     (KEY_WIDTH),
                .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_cmp_en      (w_in_fire),
                .i_cmp_key     (i_device_key),
                .i_live        (w_live[g]),
                .i_seen        (w_seen[g]),
                .o_seen        (w_seen[g+1]),
                .o_first       (w_first[g]),
                .i_ctl         (w_ctl[g]),
                .i_wr_key      (r_key),
                .i_wr_profile  (r_profile),
                .i_wr_payload  (r_payload),
                .i_nxt_key     (w_cell_key[NXT]),
                .i_nxt_profile (w_cell_profile[NXT]),
                .i_nxt_payload (w_cell_payload[NXT]),
                .o_key         (w_cell_key[g]),
                .o_profile     (w_cell_profile[g]),
                .o_payload     (w_cell_payload[g])
            );
        end
    endgenerate

    always_comb begin
        w_first_idx   = '0;
        w_sel_key     = '0;
        w_sel_profile = '0;
        w_sel_payload = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_pick[i] = (r_op == krt_pkg::OP_GET) ? (r_pos == IW'(i)) & w_live[i]
                                                  : w_first[i];
            w_first_idx   = w_first_idx   | (w_first[i] ? IW'(i) : '0);
            w_sel_key     = w_sel_key     | (w_pick[i] ? w_cell_key[i] : '0);
            w_sel_profile = w_sel_profile | (w_pick[i] ? w_cell_profile[i] : '0);
            w_sel_payload = w_sel_payload | (w_pick[i] ? w_cell_payload[i] : '0);
        end
    end

    assign w_pos_ok  = (CW'(r_pos) < r_count);
    assign w_prof_ok = ({1'b0, r_profile} < PROF_LIM);

    always_comb begin
        n_success     = 1'b0;
        n_hit_index   = '0;
        n_hit_key     = '0;
        n_hit_profile = '0;
        n_hit_payload = '0;
        n_count       = r_count;
        n_wr_entry    = '0;
        n_wr_profile  = '0;
        n_shift       = '0;
        unique case (r_op)
            krt_pkg::OP_ADD: begin
                if (w_any) begin
                    n_wr_entry  = w_first;
                    n_success   = 1'b1;
                    n_hit_index = w_first_idx;
                end else if (r_count < r_cap) begin
                    n_wr_entry  = w_append;
                    n_success   = 1'b1;
                    n_hit_index = r_count[IW-1:0];
                    n_count     = r_count + CW'(1);
                end
                if (n_success) begin
                    n_hit_key     = r_key;
                    n_hit_profile = r_profile;
                    n_hit_payload = r_payload;
                end
            end
            krt_pkg::OP_REMOVE: begin
                if (w_any) begin
                    n_shift       = w_seen[TABLE_DEPTH:1];
                    n_success     = 1'b1;
                    n_hit_index   = w_first_idx;
                    n_hit_key     = w_sel_key;
                    n_hit_profile = w_sel_profile;
                    n_hit_payload = w_sel_payload;
                    n_count       = r_count - CW'(1);
                end
            end
            krt_pkg::OP_FIND: begin
                if (w_any) begin
                    n_success     = 1'b1;
                    n_hit_index   = w_first_idx;
                    n_hit_key     = w_sel_key;
                    n_hit_profile = w_sel_profile;
                    n_hit_payload = w_sel_payload;
                end
            end
            krt_pkg::OP_SET_PROF: begin
                if (w_any && w_prof_ok) begin
                    n_wr_profile  = w_first;
                    n_success     = 1'b1;
                    n_hit_index   = w_first_idx;
                    n_hit_key     = w_sel_key;
                    n_hit_profile = r_profile;
                    n_hit_payload = w_sel_payload;
                end
            end
            krt_pkg::OP_GET: begin
                if (w_pos_ok) begin
                    n_success     = 1'b1;
                    n_hit_index   = r_pos;
                    n_hit_key     = w_sel_key;
                    n_hit_profile = w_sel_profile;
                    n_hit_payload = w_sel_payload;
                end
            end
            default: begin
            end
        endcase
        if (!w_go) begin
            n_wr_entry   = '0;
            n_wr_profile = '0;
            n_shift      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= krt_pkg::S_IDLE;
            r_count     <= '0;
            r_cap       <= CW'(CAP_RST);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cap <= CW'((w_cfg_ext > DEPTH_C) ? DEPTH_C : w_cfg_ext);
            end
            if (w_in_fire) begin
                r_state <= krt_pkg::S_EXEC;
            end else if (w_go) begin
                r_state <= krt_pkg::S_IDLE;
            end
            if (w_go) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_op      <= krt_pkg::t_op'(i_operation);
            r_key     <= i_device_key;
            r_profile <= i_new_profile;
            r_payload <= i_new_payload;
            r_pos     <= i_position;
        end
        if (w_go) begin
            r_success     <= n_success;
            r_hit_index   <= n_hit_index;
            r_hit_key     <= n_hit_key;
            r_hit_profile <= n_hit_profile;
            r_hit_payload <= n_hit_payload;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_success     = r_success;
    assign o_hit_index   = r_hit_index;
    assign o_hit_key     = r_hit_key;
    assign o_hit_profile = r_hit_profile;
    assign o_hit_payload = r_hit_payload;
    assign o_entry_count = r_count;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_first_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_first))
        else $error("more than one first match in the row");

    a_go_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go |=> (r_state == krt_pkg::S_IDLE) && r_out_valid)
        else $error("update cycle did not finish the item");

    a_remove_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && (r_op == krt_pkg::OP_REMOVE) && w_any) |=>
        (r_count == $past(r_count) - CW'(1)))
        else $error("remove did not drop the count");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_success) |->
        (r_hit_index == '0) && (r_hit_key == '0) && (r_hit_payload == '0))
        else $error("failed result carries entry data");
`endif

endmodule

`default_nettype wire

// File: test/tb_keyed_record_table_top.sv
// tb_keyed_record_table_top: self-checking bench for the keyed record table.
// Directed and random table operations across several capacity settings, scored
// against an in-bench table model. Depends on krt_pkg and keyed_record_table_top.

module tb_keyed_record_table_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TableDepth    = krt_pkg::TableDepth;
    localparam int KeyWidth      = krt_pkg::KeyWidth;
    localparam int PayloadWidth  = krt_pkg::PayloadWidth;
    localparam int ProfileW      = krt_pkg::ProfileW;
    localparam int ProfileLimit  = krt_pkg::ProfileLimit;
    localparam int CfgW          = krt_pkg::CfgW;
    localparam int CapacityReset = krt_pkg::CapacityReset;

    localparam int IdxW          = $clog2(TableDepth);
    localparam int CntW          = $clog2(TableDepth + 1);
    localparam int PoolSize      = 20;
    localparam int NumPhases     = 10;
    localparam int PhaseItems    = 193;
    localparam int WatchdogLimit = 2000;
    localparam int ReportLimit   = 10;
    localparam logic [2:0] OpBadLo = 3'd5;
    localparam logic [2:0] OpBadHi = 3'd7;

    typedef struct packed {
        logic [2:0]              op;
        logic [KeyWidth-1:0]     key;
        logic [ProfileW-1:0]     profile;
        logic [PayloadWidth-1:0] payload;
        logic [IdxW-1:0]         position;
        logic                    drain_first;
    } t_request;

    typedef struct packed {
        logic                    success;
        logic [IdxW-1:0]         index;
        logic [KeyWidth-1:0]     key;
        logic [ProfileW-1:0]     profile;
        logic [PayloadWidth-1:0] payload;
        logic [CntW-1:0]         count;
    } t_reply;

    typedef enum logic [1:0] {RxOpen, RxCoin, RxSparse, RxPulse} t_rx_mode;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    logic               cfg_valid = 1'b0;
    logic [CfgW-1:0]    cfg_data  = '0;
    logic               cfg_ready;

    logic                    in_valid    = 1'b0;
    logic                    in_ready;
    logic [2:0]              in_op       = '0;
    logic [KeyWidth-1:0]     in_key      = '0;
    logic [ProfileW-1:0]     in_profile  = '0;
    logic [PayloadWidth-1:0] in_payload  = '0;
    logic [IdxW-1:0]         in_position = '0;

    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic                    out_success;
    logic [IdxW-1:0]         out_index;
    logic [KeyWidth-1:0]     out_key;
    logic [ProfileW-1:0]     out_profile;
    logic [PayloadWidth-1:0] out_payload;
    logic [CntW-1:0]         out_count;

    keyed_record_table_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_operation   (in_op),
        .i_device_key  (in_key),
        .i_new_profile (in_profile),
        .i_new_payload (in_payload),
        .i_position    (in_position),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_success     (out_success),
        .o_hit_index   (out_index),
        .o_hit_key     (out_key),
        .o_hit_profile (out_profile),
        .o_hit_payload (out_payload),
        .o_entry_count (out_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // table model state
    logic [KeyWidth-1:0]     tbl_key [TableDepth];
    logic [ProfileW-1:0]     tbl_profile [TableDepth];
    logic [PayloadWidth-1:0] tbl_payload [TableDepth];
    int                      tbl_count = 0;
    int                      tbl_cap   = CapacityReset;

    t_request table_requests[$];
    t_reply   table_replies[$];
    logic [KeyWidth-1:0] key_pool [PoolSize];

    int unsigned phase_cap [NumPhases] = '{16, 0, 31, 1, 17, 5, 16, 8, 2, 16};
    int unsigned phase_add [NumPhases] = '{45, 30, 60, 40, 50, 25, 55, 30, 40, 35};

    int bad_replies = 0;
    int n_accepted  = 0;
    int n_replies   = 0;
    int n_success   = 0;
    int n_cfg       = 0;
    int peak_count  = 0;
    int op_seen [8] = '{default: 0};
    int idle_cycles = 0;

    function automatic t_reply entry_reply(int w);
        t_reply r;
        r.success = 1'b1;
        r.index   = w[IdxW-1:0];
        r.key     = tbl_key[w];
        r.profile = tbl_profile[w];
        r.payload = tbl_payload[w];
        r.count   = '0;
        return r;
    endfunction

    function automatic t_reply apply_table_op(t_request rq);
        t_reply r;
        int w;
        int eff_cap;
        bit hit;
        r = '0;
        w = 0;
        hit = 1'b0;
        eff_cap = (tbl_cap > TableDepth) ? TableDepth : tbl_cap;
        for (int i = 0; i < tbl_count; i++) begin
            if (!hit && tbl_key[i] == rq.key) begin
                hit = 1'b1;
                w = i;
            end
        end
        case (rq.op)
            krt_pkg::OP_ADD: begin
                if (!hit && tbl_count < eff_cap) begin
                    w = tbl_count;
                    tbl_count++;
                    hit = 1'b1;
                end
                if (hit) begin
                    tbl_key[w]     = rq.key;
                    tbl_profile[w] = rq.profile;
                    tbl_payload[w] = rq.payload;
                    r = entry_reply(w);
                end
            end
            krt_pkg::OP_REMOVE: begin
                if (hit) begin
                    r = entry_reply(w);
                    for (int i = w + 1; i < tbl_count; i++) begin
                        tbl_key[i-1]     = tbl_key[i];
                        tbl_profile[i-1] = tbl_profile[i];
                        tbl_payload[i-1] = tbl_payload[i];
                    end
                    tbl_count--;
                end
            end
            krt_pkg::OP_FIND: begin
                if (hit) r = entry_reply(w);
            end
            krt_pkg::OP_SET_PROF: begin
                if (hit && rq.profile < ProfileLimit) begin
                    tbl_profile[w] = rq.profile;
                    r = entry_reply(w);
                end
            end
            krt_pkg::OP_GET: begin
                if (int'(rq.position) < tbl_count) r = entry_reply(int'(rq.position));
            end
            default: ;
        endcase
        r.count = tbl_count[CntW-1:0];
        if (tbl_count > peak_count) peak_count = tbl_count;
        return r;
    endfunction

    function automatic t_request random_request(int unsigned add_pct);
        t_request rq;
        int unsigned pick;
        rq.payload     = $urandom;
        rq.position    = IdxW'($urandom_range(0, TableDepth - 1));
        rq.profile     = ProfileW'($urandom);
        rq.drain_first = ($urandom_range(0, 99) == 0);
        rq.key = ($urandom_range(0, 9) == 0) ? KeyWidth'($urandom)
                                              : key_pool[$urandom_range(0, PoolSize - 1)];
        pick = $urandom_range(0, 19);
        if ($urandom_range(0, 99) < add_pct) rq.op = krt_pkg::OP_ADD;
        else if (pick < 5)  rq.op = krt_pkg::OP_REMOVE;
        else if (pick < 10) rq.op = krt_pkg::OP_FIND;
        else if (pick < 15) rq.op = krt_pkg::OP_SET_PROF;
        else if (pick < 19) rq.op = krt_pkg::OP_GET;
        else                rq.op = 3'($urandom_range(OpBadLo, OpBadHi));
        if (rq.op == krt_pkg::OP_SET_PROF && $urandom_range(0, 9) < 7)
            rq.profile = ProfileW'($urandom_range(0, ProfileLimit - 1));
        return rq;
    endfunction

    task automatic queue_request(input logic [2:0] op, input logic [KeyWidth-1:0] key,
                                 input logic [ProfileW-1:0] profile,
                                 input logic [PayloadWidth-1:0] payload,
                                 input logic [IdxW-1:0] position);
        t_request rq;
        rq = '{op: op, key: key, profile: profile, payload: payload,
               position: position, drain_first: 1'b0};
        table_requests.push_back(rq);
    endtask

    task automatic wait_idle();
        while (table_requests.size() != 0 || in_valid || table_replies.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [CfgW-1:0] value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tbl_cap = int'(value);
        n_cfg++;
    endtask

    task automatic note_error(input string msg);
        bad_replies++;
        if (bad_replies <= ReportLimit) $display("%t ERROR %s", $realtime, msg);
    endtask

    // sender: bursts of random length separated by random gaps
    int       burst_left = 4;
    int       gap_left   = 0;
    t_request cur_req    = '0;

    always @(posedge i_clk) begin
        logic load;
        load = 1'b0;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                table_replies.push_back(apply_table_op(cur_req));
                n_accepted++;
                op_seen[cur_req.op]++;
            end
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (table_requests.size() != 0 &&
                             !(table_requests[0].drain_first && table_replies.size() != 0)) begin
                    load = 1'b1;
                    cur_req = table_requests.pop_front();
                    in_op       <= cur_req.op;
                    in_key      <= cur_req.key;
                    in_profile  <= cur_req.profile;
                    in_payload  <= cur_req.payload;
                    in_position <= cur_req.position;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                in_valid <= load;
            end
        end
    end

    // receiver: stall pattern switches among a few modes
    t_rx_mode rx_mode = RxOpen;
    int       rx_left = 50;

    always @(posedge i_clk) begin
        t_reply got;
        t_reply want;
        logic   rdy;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                got = '{success: out_success, index: out_index, key: out_key,
                        profile: out_profile, payload: out_payload, count: out_count};
                n_replies++;
                if (got.success) n_success++;
                if (table_replies.size() == 0) begin
                    note_error($sformatf("unexpected transfer: ok=%0b idx=%0d key=%h cnt=%0d",
                                         got.success, got.index, got.key, got.count));
                end else begin
                    want = table_replies.pop_front();
                    if (got.success !== want.success || got.index !== want.index ||
                        got.key !== want.key || got.profile !== want.profile ||
                        got.payload !== want.payload || got.count !== want.count)
                        note_error($sformatf({"reply %0d: exp ok=%0b idx=%0d key=%h prof=%0d ",
                            "pay=%h cnt=%0d / got ok=%0b idx=%0d key=%h prof=%0d pay=%h cnt=%0d"},
                            n_replies, want.success, want.index, want.key, want.profile,
                            want.payload, want.count, got.success, got.index, got.key,
                            got.profile, got.payload, got.count));
                end
            end
            if (rx_left <= 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_left = $urandom_range(20, 200);
            end
            rx_left--;
            case (rx_mode)
                RxOpen:   rdy = 1'b1;
                RxCoin:   rdy = 1'($urandom_range(0, 1));
                RxSparse: rdy = ($urandom_range(0, 3) == 0);
                default:  rdy = (rx_left % 12 == 0);
            endcase
            out_ready <= rdy;
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("watchdog: no transfer for %0d cycles, %0d replies outstanding",
                     idle_cycles, table_replies.size());
            $display("tb_keyed_record_table_top: done, errors");
            $finish;
        end
    end

    initial begin
        logic [KeyWidth-1:0] k_lo;
        logic [KeyWidth-1:0] k_hi;
        t_request rq;
        k_lo = '0;
        k_hi = '1;
        key_pool[0] = k_lo;
        key_pool[1] = k_hi;
        for (int i = 2; i < PoolSize; i++) key_pool[i] = $urandom;

        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;

        // directed: empty table, extremes, update, profile range, bad codes, shift
        queue_request(krt_pkg::OP_GET,      k_lo, '0, '0, '0);
        queue_request(krt_pkg::OP_FIND,     k_lo, '0, '0, '0);
        queue_request(krt_pkg::OP_REMOVE,   k_lo, '0, '0, '0);
        queue_request(krt_pkg::OP_SET_PROF, k_lo, 4'd1, '0, '0);
        queue_request(krt_pkg::OP_ADD,      k_lo, '1, '0, '0);
        queue_request(krt_pkg::OP_ADD,      k_hi, '0, '1, '1);
        queue_request(krt_pkg::OP_ADD,      k_lo, 4'd3, 32'hA5A5_A5A5, '0);
        queue_request(krt_pkg::OP_FIND,     k_hi, '0, '0, '0);
        queue_request(krt_pkg::OP_SET_PROF, k_lo, ProfileW'(ProfileLimit - 1), '0, '0);
        queue_request(krt_pkg::OP_SET_PROF, k_lo, ProfileW'(ProfileLimit), '0, '0);
        queue_request(krt_pkg::OP_SET_PROF, k_hi, '1, '0, '0);
        queue_request(krt_pkg::OP_GET,      k_lo, '0, '0, 4'd1);
        queue_request(krt_pkg::OP_GET,      k_lo, '0, '0, 4'd2);
        queue_request(krt_pkg::OP_GET,      k_lo, '0, '0, '1);
        for (int op = OpBadLo; op <= OpBadHi; op++)
            queue_request(3'(op), k_hi, '1, '1, '1);
        queue_request(krt_pkg::OP_REMOVE,   k_lo, '0, '0, '0);
        queue_request(krt_pkg::OP_GET,      k_lo, '0, '0, '0);
        queue_request(krt_pkg::OP_ADD,      32'h5A5A_5A5A, 4'd8, 32'h5A5A_5A5A, '0);
        queue_request(krt_pkg::OP_REMOVE,   k_hi, '0, '0, '0);
        queue_request(krt_pkg::OP_FIND,     32'h5A5A_5A5A, '0, '0, '0);
        queue_request(krt_pkg::OP_GET,      k_lo, '0, '0, '0);

        for (int p = 0; p < NumPhases; p++) begin
            wait_idle();
            write_capacity(CfgW'(phase_cap[p]));
            for (int n = 0; n < PhaseItems; n++) begin
                rq = random_request(phase_add[p]);
                table_requests.push_back(rq);
            end
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        $display("ran %0d ops (add %0d, remove %0d, find %0d, set %0d, get %0d, bad %0d)",
                 n_accepted, op_seen[krt_pkg::OP_ADD], op_seen[krt_pkg::OP_REMOVE],
                 op_seen[krt_pkg::OP_FIND], op_seen[krt_pkg::OP_SET_PROF],
                 op_seen[krt_pkg::OP_GET], op_seen[5] + op_seen[6] + op_seen[7]);
        $display("%0d replies, %0d successful, peak occupancy %0d, %0d capacity writes, %0d bad",
                 n_replies, n_success, peak_count, n_cfg, bad_replies);
        if (bad_replies == 0)
            $display("tb_keyed_record_table_top: done, clean");
        else
            $display("tb_keyed_record_table_top: done, errors");
        $finish;
    end

endmodule
